// ----- rtl/button_multi_press_decoder_unit_defines.svh -----
// Assertion macros shared by the RTL of the button multi-press decoder.
// Each macro checks an implication on the rising clock edge, ignored in reset.
`ifndef BUTTON_MULTI_PRESS_DECODER_UNIT_DEFINES_SVH
`define BUTTON_MULTI_PRESS_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BMPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define BMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BMPD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/bmpd_pkg.sv -----
package bmpd_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 8;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd35;
  localparam logic [15:0] GAP_RESET      = 16'd500;

  localparam int SPECIAL_COUNT_A = 12;
  localparam int SPECIAL_COUNT_B = 20;

  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GAP  = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUSTOM   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYPASS   = 4'd3;

  localparam logic [1:0] DRIVE_NONE  = 2'd0;
  localparam logic [1:0] DRIVE_RAISE = 2'd1;
  localparam logic [1:0] DRIVE_LOWER = 2'd2;

  typedef struct packed {
    logic        button_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       activity;
    logic [1:0] drive_cmd;
    logic       action_valid;
    logic [7:0] action_index;
  } out_item_t;

  typedef struct packed {
    logic [15:0] settle_ms;
    logic [15:0] max_gap_ms;
    logic        custom_mode;
    logic        bypass_enable;
  } cfg_t;

endpackage

// ----- rtl/bmpd_cfg.sv -----
module bmpd_cfg
  import bmpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  output cfg_t                    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_nxt.settle_ms     = cfg_data;
        CFG_MAX_GAP:  cfg_nxt.max_gap_ms    = cfg_data;
        CFG_CUSTOM:   cfg_nxt.custom_mode   = cfg_data[0];
        CFG_BYPASS:   cfg_nxt.bypass_enable = cfg_data[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms     <= DEBOUNCE_RESET;
      cfg_r.max_gap_ms    <= GAP_RESET;
      cfg_r.custom_mode   <= 1'b0;
      cfg_r.bypass_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/bmpd_core.sv -----
module bmpd_core
  import bmpd_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      commit,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic                  last_level_r, last_level_nxt;
  logic [TIME_BITS-1:0]  edge_time_r, edge_time_nxt;
  logic                  pending_r, pending_nxt;
  logic                  glitch_r, glitch_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  elapsed;
  logic [TIME_BITS-1:0]  elapsed_eff;
  logic [TIME_BITS-1:0]  debounce_ext;
  logic [TIME_BITS-1:0]  gap_ext;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] idx;
  logic                  differ;
  logic                  glitch_hit;
  logic                  report_ok;

  assign now          = TIME_BITS'(item.now_ms);
  assign elapsed      = now - edge_time_r;
  assign debounce_ext = TIME_BITS'(cfg.settle_ms);
  assign gap_ext      = TIME_BITS'(cfg.max_gap_ms);
  assign differ       = item.button_level != last_level_r;
  assign glitch_hit   = pending_r && differ && (elapsed <= debounce_ext);
  // A fresh edge restarts the clock, so no press or timeout fires on that poll.
  assign elapsed_eff  = differ ? '0 : elapsed;
  assign count_inc    = (count_r == '1) ? count_r : count_r + COUNT_BITS'(1);
  assign idx          = count_r - COUNT_BITS'(1);
  assign report_ok    = cfg.custom_mode
                     || (count_r == COUNT_BITS'(SPECIAL_COUNT_A))
                     || (count_r == COUNT_BITS'(SPECIAL_COUNT_B));

  always_comb begin
    last_level_nxt = item.button_level;
    edge_time_nxt  = edge_time_r;
    pending_nxt    = pending_r;
    glitch_nxt     = glitch_r;
    count_nxt      = count_r;

    result.activity     = differ;
    result.drive_cmd    = DRIVE_NONE;
    result.action_valid = 1'b0;
    result.action_index = 8'd0;

    if (glitch_hit) begin
      pending_nxt = 1'b0;
      if (!cfg.bypass_enable) begin
        glitch_nxt     = 1'b0;
        count_nxt      = '0;
        last_level_nxt = last_level_r;
      end else begin
        glitch_nxt = 1'b1;
        count_nxt  = count_inc;
      end
    end else begin
      if (differ) begin
        edge_time_nxt = now;
        glitch_nxt    = 1'b0;
        pending_nxt   = 1'b1;
      end
      priority if (!glitch_nxt && pending_nxt && (elapsed_eff > debounce_ext)) begin
        pending_nxt = 1'b0;
        count_nxt   = count_inc;
        if (!cfg.custom_mode) begin
          result.drive_cmd = last_level_r ? DRIVE_RAISE : DRIVE_LOWER;
        end
      end else if ((count_r != '0) && (elapsed_eff > gap_ext)) begin
        if (report_ok) begin
          result.action_valid = 1'b1;
          result.action_index = (32'(idx) > 32'd255) ? 8'hFF : 8'(idx);
        end
        count_nxt = '0;
      end else begin
        count_nxt = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      edge_time_r  <= '0;
      pending_r    <= 1'b0;
      glitch_r     <= 1'b0;
      count_r      <= '0;
    end else if (commit) begin
      last_level_r <= last_level_nxt;
      edge_time_r  <= edge_time_nxt;
      pending_r    <= pending_nxt;
      glitch_r     <= glitch_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

// ----- rtl/button_multi_press_decoder_unit.sv -----
// Button multi-press decoder: each input beat is one poll of the button (level and a
// free-running millisecond time) and yields exactly one result beat, in order. A poll
// is captured in an input register, the debounce and press-count update runs in
// combinational logic, and the result lands in an output register, so the block takes
// one poll per cycle when the output is not stalled; a poll passes from the input
// register to the output register; two register stages, input port to output port.
// The only limit on the rate is the output stall: while the output register holds an
// untaken result, one more poll waits in the input register before in_stall rises.
// Configuration writes are always ready and take effect on the next cycle; write them
// only while no poll is in flight.
`include "button_multi_press_decoder_unit_defines.svh"

module button_multi_press_decoder_unit
  import bmpd_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data
);

  cfg_t      cfg;
  out_item_t core_result;
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      advance;
  logic      commit;
  logic      out_drives;
  logic      settle_write;

  bmpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmpd_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (core_result)
  );

  // The output register can load whenever it is empty or its beat is leaving.
  assign advance   = !out_valid_r || !out_stall;
  assign commit    = advance && in_valid_r;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_valid_nxt  = in_stall ? in_valid_r : in_valid;
  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (commit) begin
      out_data_r <= core_result;
    end
  end

  assign out_drives   = out_valid_r && (out_data_r.drive_cmd != DRIVE_NONE);
  assign settle_write = cfg_valid && (cfg_index == CFG_DEBOUNCE);

  `BMPD_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, in_valid && !in_stall, in_valid_r)
  `BMPD_ASSERT_NEXT(a_commit_gives_result, clk, rst_n, commit, out_valid_r)
  `BMPD_ASSERT_SAME(a_drive_excludes_action, clk, rst_n, out_drives, !out_data_r.action_valid)
  `BMPD_ASSERT_NEXT(a_cfg_settle_write, clk, rst_n, settle_write, cfg.settle_ms == $past(cfg_data))

endmodule

// ----- bench/tb_button_multi_press_decoder_unit.sv -----
`timescale 1ns / 100ps

module tb_button_multi_press_decoder_unit;
  import bmpd_pkg::*;

  localparam int RANDOM_POLLS   = 900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct {
    bit                      is_cfg;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [15:0]             reg_data;
    logic                    level;
    logic [31:0]             now;
    bit                      pinned;
    out_item_t               result;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Hand-written result that replaces the prediction for the beat being offered.
  bit lit_on = 1'b0;
  out_item_t lit_result = '0;

  // Decoder state and settings as the bench sees them.
  logic        line_q;
  logic [31:0] edge_ms;
  logic        settling;
  logic        glitch_flag;
  logic [7:0]  presses;
  logic [15:0] debounce_win;
  logic [15:0] gap_limit;
  logic        custom_on;
  logic        bypass_on;

  out_item_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int polls_sent = 0;
  int calm_in = 0;
  int stall_left = 0;
  int calm_out = 0;
  logic [31:0] wall_ms = '0;
  script_row_t script[$];

  button_multi_press_decoder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reset_decoder();
    line_q       = 1'b0;
    edge_ms      = '0;
    settling     = 1'b0;
    glitch_flag  = 1'b0;
    presses      = '0;
    debounce_win = DEBOUNCE_RESET;
    gap_limit    = GAP_RESET;
    custom_on    = 1'b0;
    bypass_on    = 1'b0;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
    case (idx)
      CFG_DEBOUNCE: debounce_win = data;
      CFG_MAX_GAP:  gap_limit = data;
      CFG_CUSTOM:   custom_on = data[0];
      CFG_BYPASS:   bypass_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic void count_press();
    if (presses != 8'hFF) presses = presses + 8'd1;
  endfunction

  function automatic out_item_t decode_poll(in_item_t p);
    out_item_t r;
    logic changed;
    logic [31:0] elapsed;
    r = '0;
    changed = p.button_level != line_q;
    elapsed = p.now_ms - edge_ms;
    r.activity = changed;
    // An edge inside the debounce window while settling is a bounce: it either counts or aborts the run.
    if (settling && changed && elapsed <= {16'd0, debounce_win}) begin
      settling = 1'b0;
      if (!bypass_on) begin
        glitch_flag = 1'b0;
        presses = '0;
      end else begin
        glitch_flag = 1'b1;
        count_press();
        line_q = p.button_level;
      end
      return r;
    end
    if (changed) begin
      edge_ms = p.now_ms;
      glitch_flag = 1'b0;
      settling = 1'b1;
      elapsed = '0;
    end
    if (!glitch_flag && settling && elapsed > {16'd0, debounce_win}) begin
      settling = 1'b0;
      count_press();
      if (!custom_on) r.drive_cmd = line_q ? DRIVE_RAISE : DRIVE_LOWER;
    end else if (presses != 0 && elapsed > {16'd0, gap_limit}) begin
      if (custom_on || presses == SPECIAL_COUNT_A || presses == SPECIAL_COUNT_B) begin
        r.action_valid = 1'b1;
        r.action_index = presses - 8'd1;
      end
      presses = '0;
    end
    line_q = p.button_level;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      reset_decoder();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_setting(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        want = decode_poll(in_data);
        pending_results.push_back(lit_on ? lit_result : want);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          if (mismatches < SHOWN_ERRORS)
            $display("unexpected result beat: act=%0b drv=%0d av=%0b idx=%0d",
                     out_data.activity, out_data.drive_cmd, out_data.action_valid,
                     out_data.action_index);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.activity !== want.activity || out_data.drive_cmd !== want.drive_cmd ||
              out_data.action_valid !== want.action_valid ||
              out_data.action_index !== want.action_index) begin
            if (mismatches < SHOWN_ERRORS)
              $display("mismatch: exp %0b/%0d/%0b/%0d, got %0b/%0d/%0b/%0d",
                       want.activity, want.drive_cmd, want.action_valid, want.action_index,
                       out_data.activity, out_data.drive_cmd, out_data.action_valid,
                       out_data.action_index);
            mismatches++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver backpressure: mostly short stalls, a few long ones, and calm stretches.
  always @(negedge clk) begin
    int r;
    if (stall_left == 0 && calm_out == 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) stall_left = $urandom_range(0, 2);
      else if (r < 95) stall_left = $urandom_range(3, 8);
      else stall_left = $urandom_range(20, 60);
      calm_out = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(0, 4);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if (calm_out != 0) calm_out--;
      out_stall <= 1'b0;
    end
  end

  function automatic int input_gap();
    int r;
    if (calm_in != 0) begin
      calm_in--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm_in = $urandom_range(50, 150);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_poll(input logic level, input logic [31:0] now, input bit pin = 1'b0,
                           input out_item_t pinned = '0);
    int gap;
    gap = input_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{button_level: level, now_ms: now};
    lit_on <= pin;
    lit_result <= pinned;
    do @(posedge clk); while (in_stall);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One run of presses: each press is an edge and a poll past the debounce window,
  // with bounces and polls inside the window mixed in unless the run is clean.
  task automatic play_sequence(input int count, input bit clean);
    logic [31:0] edge_at;
    logic lvl;
    for (int n = 0; n < count; n++) begin
      lvl = !line_q;
      wall_ms += $urandom_range(1, 5);
      edge_at = wall_ms;
      send_poll(lvl, edge_at);
      if (!clean && $urandom_range(0, 9) == 0) begin
        wall_ms = edge_at + $urandom_range(0, debounce_win);
        send_poll(!lvl, wall_ms);
        continue;
      end
      if (!clean && $urandom_range(0, 2) == 0)
        send_poll(lvl, edge_at + $urandom_range(0, debounce_win));
      wall_ms = edge_at + debounce_win + 32'd1 + $urandom_range(0, 3);
      send_poll(lvl, wall_ms);
    end
    // Sometimes the run is left open so the next one keeps counting.
    if (clean || $urandom_range(0, 4) != 0) begin
      wall_ms += gap_limit + 32'd1 + $urandom_range(0, 20);
      send_poll(line_q, wall_ms);
    end
  endtask

  function automatic script_row_t poll_row(logic level, logic [31:0] now, bit pin = 1'b0,
                                           out_item_t result = '0);
    script_row_t row;
    row = '{is_cfg: 1'b0, reg_idx: '0, reg_data: '0, level: level, now: now,
            pinned: pin, result: result};
    return row;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
    script_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_data: data, level: 1'b0, now: '0,
            pinned: 1'b0, result: '0};
    return row;
  endfunction

  initial begin
    int phase;
    int phase_start;
    int r;
    int count;
    logic [15:0] deb_sel;
    logic [15:0] gap_sel;
    logic custom_sel;
    logic bypass_sel;

    // Default settings first: press, release, timeout and a bounce that aborts.
    script.push_back(poll_row(1'b0, 32'h0, 1'b1, '{1'b0, DRIVE_NONE, 1'b0, 8'd0}));
    script.push_back(poll_row(1'b1, 32'd100, 1'b1, '{1'b1, DRIVE_NONE, 1'b0, 8'd0}));
    script.push_back(poll_row(1'b1, 32'd136, 1'b1, '{1'b0, DRIVE_RAISE, 1'b0, 8'd0}));
    script.push_back(poll_row(1'b0, 32'd200));
    script.push_back(poll_row(1'b0, 32'd236, 1'b1, '{1'b0, DRIVE_LOWER, 1'b0, 8'd0}));
    script.push_back(poll_row(1'b0, 32'd737, 1'b1, '{1'b0, DRIVE_NONE, 1'b0, 8'd0}));
    script.push_back(poll_row(1'b1, 32'd800));
    script.push_back(poll_row(1'b0, 32'd835, 1'b1, '{1'b1, DRIVE_NONE, 1'b0, 8'd0}));
    // Elapsed time across the wrap of the millisecond counter.
    script.push_back(poll_row(1'b1, 32'hFFFF_FFF0));
    script.push_back(poll_row(1'b0, 32'hFFFF_FFF0));
    script.push_back(poll_row(1'b0, 32'h0000_0013));
    script.push_back(poll_row(1'b0, 32'h0000_0014));
    script.push_back(poll_row(1'b0, 32'hFFFF_FFFF));
    // A bounce that counts, then a custom-mode report of the run.
    script.push_back(cfg_row(CFG_BYPASS, 16'hFFFF));
    script.push_back(poll_row(1'b1, 32'h0000_1000));
    script.push_back(poll_row(1'b0, 32'h0000_1005));
    script.push_back(poll_row(1'b0, 32'h0000_1100));
    script.push_back(cfg_row(CFG_CUSTOM, 16'h0001));
    script.push_back(poll_row(1'b0, 32'h0000_1300, 1'b1, '{1'b0, DRIVE_NONE, 1'b1, 8'd1}));
    script.push_back(cfg_row(CFG_DEBOUNCE, 16'h0000));
    script.push_back(poll_row(1'b1, 32'h0000_2000));
    script.push_back(poll_row(1'b1, 32'h0000_2001));
    script.push_back(cfg_row(CFG_MAX_GAP, 16'h0000));
    script.push_back(poll_row(1'b1, 32'h0000_2002, 1'b1, '{1'b0, DRIVE_NONE, 1'b1, 8'd0}));
    script.push_back(cfg_row(4'hF, 16'hFFFF));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_setting(script[i].reg_idx, script[i].reg_data);
      else send_poll(script[i].level, script[i].now, script[i].pinned, script[i].result);
    end

    polls_sent = 0;
    phase = 0;
    while (polls_sent < RANDOM_POLLS) begin
      case (phase)
        0: begin
          deb_sel = 16'd0; gap_sel = 16'd0; custom_sel = 1'b0; bypass_sel = 1'b0;
        end
        1: begin
          deb_sel = 16'hFFFF; gap_sel = 16'hFFFF; custom_sel = 1'b1; bypass_sel = 1'b1;
        end
        2: begin
          // Long clean run that drives the press count into saturation.
          deb_sel = 16'($urandom_range(0, 20)); gap_sel = 16'd1000;
          custom_sel = 1'b1; bypass_sel = 1'b0;
        end
        default: begin
          r = $urandom_range(0, 99);
          deb_sel = (r < 15) ? 16'd0 : (r < 25) ? 16'hFFFF :
                    (r < 60) ? 16'($urandom_range(1, 60)) : 16'($urandom_range(0, 400));
          r = $urandom_range(0, 99);
          gap_sel = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF :
                    (r < 45) ? 16'($urandom_range(1, 100)) : 16'($urandom_range(100, 2000));
          custom_sel = 1'($urandom_range(0, 1));
          bypass_sel = ($urandom_range(0, 3) == 0);
        end
      endcase
      write_setting(CFG_DEBOUNCE, deb_sel);
      write_setting(CFG_MAX_GAP, gap_sel);
      write_setting(CFG_CUSTOM, 16'($urandom_range(0, 16'hFFFF)) & 16'hFFFE | 16'(custom_sel));
      write_setting(CFG_BYPASS, 16'($urandom_range(0, 16'hFFFF)) & 16'hFFFE | 16'(bypass_sel));
      write_setting(4'($urandom_range(4, 15)), 16'($urandom_range(0, 16'hFFFF)));

      wall_ms = $urandom;
      if (phase == 2) begin
        play_sequence(258, 1'b1);
      end else begin
        phase_start = polls_sent;
        while (polls_sent - phase_start < 70) begin
          if ($urandom_range(0, 6) == 0) begin
            wall_ms = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : wall_ms + $urandom_range(0, 3000);
            send_poll(1'($urandom_range(0, 1)), wall_ms);
          end else begin
            r = $urandom_range(0, 99);
            if (r < 25) count = 12;
            else if (r < 40) count = 20;
            else if (r < 50) count = 11 + 2 * $urandom_range(0, 1);
            else if (r < 60) count = 19 + 2 * $urandom_range(0, 1);
            else count = $urandom_range(1, 8);
            play_sequence(count, 1'b0);
          end
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
